// ===== rtl/core/cdps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdps_pkg
// Widths, reset values and register indexes of the clock divider pair search.
// ----------------------------------------------------------------------------
package cdps_pkg;

   // search limits
   localparam int FIRST_DIVIDER_LIMIT = 32;
   localparam int SECOND_DIVIDER_BITS = 16;

   // field widths
   localparam int CLK_W        = 32;
   localparam int FIRST_MAX_W  = 6;
   localparam int SECOND_MAX_W = 16;
   localparam int ICM_W        = 32;
   localparam int FIRST_OUT_W  = 6;
   localparam int SECOND_OUT_W = 16;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_MAX  = 2'd0,
      CSR_SECOND_MAX = 2'd1,
      CSR_ICM_MAX    = 2'd2
   } csr_index_type;

   localparam logic [FIRST_MAX_W-1:0]  FIRST_MAX_RST  = 6'd32;
   localparam logic [SECOND_MAX_W-1:0] SECOND_MAX_RST = 16'hFFFF;
   localparam logic [ICM_W-1:0]        ICM_MAX_RST    = 32'd100000000;

   // datapath widths
   localparam int K_W    = $clog2(FIRST_DIVIDER_LIMIT + 2);
   localparam int D_W    = CLK_W + K_W;
   localparam int N_W    = D_W + 2;
   localparam int DEN_W  = K_W + SECOND_DIVIDER_BITS;
   localparam int PROD_W = N_W + DEN_W;
   localparam int CNT_W  = $clog2(((N_W > DEN_W) ? N_W : DEN_W) + 1);
   localparam int KC_W   = (K_W > FIRST_MAX_W) ? K_W : FIRST_MAX_W;

endpackage

// ===== rtl/core/cdps_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdps channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface cdps_req_if;
   import cdps_pkg::*;

   logic             valid;
   logic             ready;
   logic [CLK_W-1:0] source_clock;
   logic [CLK_W-1:0] target_clock;

   modport source (output valid, output source_clock, output target_clock, input ready);
   modport sink   (input valid, input source_clock, input target_clock, output ready);
endinterface

interface cdps_rsp_if;
   import cdps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    found;
   logic [FIRST_OUT_W-1:0]  first_divider;
   logic [SECOND_OUT_W-1:0] second_divider;

   modport source (output valid, output found, output first_divider,
                   output second_divider, input ready);
   modport sink   (input valid, input found, input first_divider,
                   input second_divider, output ready);
endinterface

interface cdps_csr_if;
   import cdps_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/clock_divider_pair_search_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_divider_pair_search_core
// Search for the first/second divider pair that best meets a target clock.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  : one beat carries source_clock and target_clock in hertz.
//   rsp_chan  : one beat per request: found, first_divider, second_divider
//               (all zero when no pair fits or the target is zero).
//   csr_chan  : register writes, always ready; index 0 first divider max,
//               1 second divider max, 2 intermediate clock max. Write only
//               while no request is in flight.
// Sequence:
//   Each first divider candidate k = 1..32 passes through a check state. An
//   eligible candidate adds a bit-serial divide, an evaluate state and,
//   once a best pair exists, a bit-serial cross-multiply and a decide
//   state. Every candidate uses the shared divide and multiply shift
//   registers. One request at a time.
// Reset and stalls:
//   Reset restores the register defaults and drops any request in flight.
//   A result waits in the output register while rsp_chan is stalled; the
//   next request is taken meanwhile and its search stops at the end only
//   until the output register is free.
// ----------------------------------------------------------------------------
module clock_divider_pair_search_core (
   input logic        clock,
   input logic        reset,
   cdps_req_if.sink   req_chan,
   cdps_rsp_if.source rsp_chan,
   cdps_csr_if.sink   csr_chan
);
   import cdps_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_DIV    = 7'b0000100,
      ST_EVAL   = 7'b0001000,
      ST_MUL    = 7'b0010000,
      ST_DECIDE = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   // control state
   state_type                 state_ff, state_in;
   logic [K_W-1:0]            k_ff, k_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      have_ff, have_in;

   // configuration registers
   logic [FIRST_MAX_W-1:0]    fmax_ff, fmax_in;
   logic [SECOND_MAX_W-1:0]   smax_ff, smax_in;
   logic [ICM_W-1:0]          icm_ff, icm_in;

   // request held for the whole search
   logic [CLK_W-1:0]          src_ff, src_in;
   logic [CLK_W-1:0]          dst_ff, dst_in;

   // bit-serial divider
   logic [N_W-2:0]            dvs_ff, dvs_in;
   logic [N_W-1:0]            numsh_ff, numsh_in;
   logic [N_W-1:0]            numk_ff, numk_in;
   logic [N_W-1:0]            rem_ff, rem_in;

   // candidate and best pair
   logic [N_W-1:0]            n_ff, n_in;
   logic [DEN_W-1:0]          den_ff, den_in;
   logic [SECOND_DIVIDER_BITS-1:0] q_ff, q_in;
   logic [N_W-1:0]            best_n_ff, best_n_in;
   logic [DEN_W-1:0]          best_den_ff, best_den_in;
   logic [K_W-1:0]            best1_ff, best1_in;
   logic [SECOND_DIVIDER_BITS-1:0] best2_ff, best2_in;

   // bit-serial cross-multiply
   logic [PROD_W-1:0]         acc_a_ff, acc_a_in;
   logic [PROD_W-1:0]         acc_b_ff, acc_b_in;
   logic [DEN_W-1:0]          sh_a_ff, sh_a_in;
   logic [DEN_W-1:0]          sh_b_ff, sh_b_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [FIRST_OUT_W-1:0]    rsp_first_ff, rsp_first_in;
   logic [SECOND_OUT_W-1:0]   rsp_second_ff, rsp_second_in;

   // combinational temporaries
   logic [ICM_W-1:0]          icm_eff;
   logic [D_W-1:0]            cand_d;
   logic [D_W-1:0]            low_prod;
   logic                      below_start;
   logic                      eligible;
   logic [N_W-1:0]            num_load;
   logic [N_W-1:0]            trial;
   logic                      trial_ge;
   logic [N_W-1:0]            p_dbl;
   logic [N_W-1:0]            p_val;
   logic [N_W-1:0]            n_cand;
   logic                      q_ok;
   logic [DEN_W-1:0]          den_cand;
   logic                      out_free;
   logic                      req_take;

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.found          = rsp_found_ff;
   assign rsp_chan.first_divider  = rsp_first_ff;
   assign rsp_chan.second_divider = rsp_second_ff;

   assign req_take = req_chan.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      // candidate check: k is below start when (k + 1) * icm <= source
      icm_eff     = (icm_ff == '0) ? ICM_W'(1) : icm_ff;
      cand_d      = D_W'(dst_ff) * D_W'(k_ff);
      low_prod    = D_W'(icm_eff) * D_W'(K_W'(k_ff + 1'b1));
      below_start = (low_prod <= D_W'(src_ff));
      eligible    = (dst_ff != '0) && (KC_W'(k_ff) <= KC_W'(fmax_ff)) && !below_start;
      // dividend 2 * source + d, divisor 2 * d: rounded quotient
      num_load    = (N_W'(src_ff) << 1) + N_W'(cand_d);

      // one restoring divide step
      trial    = {rem_ff[N_W-2:0], numsh_ff[N_W-1]};
      trial_ge = (trial >= N_W'(dvs_ff));

      // numsh holds the quotient, rem the remainder; d * q = (N - r) / 2
      p_dbl    = numk_ff - rem_ff;
      p_val    = {1'b0, p_dbl[N_W-1:1]};
      n_cand   = (p_val > N_W'(src_ff)) ? (p_val - N_W'(src_ff)) : (N_W'(src_ff) - p_val);
      q_ok     = (numsh_ff != '0)
               && (numsh_ff[N_W-1:SECOND_DIVIDER_BITS] == '0)
               && (numsh_ff <= N_W'(smax_ff));
      den_cand = DEN_W'(k_ff) * DEN_W'(numsh_ff[SECOND_DIVIDER_BITS-1:0]);
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      cnt_in        = cnt_ff;
      have_in       = have_ff;
      fmax_in       = fmax_ff;
      smax_in       = smax_ff;
      icm_in        = icm_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      dvs_in        = dvs_ff;
      numsh_in      = numsh_ff;
      numk_in       = numk_ff;
      rem_in        = rem_ff;
      n_in          = n_ff;
      den_in        = den_ff;
      q_in          = q_ff;
      best_n_in     = best_n_ff;
      best_den_in   = best_den_ff;
      best1_in      = best1_ff;
      best2_in      = best2_ff;
      acc_a_in      = acc_a_ff;
      acc_b_in      = acc_b_ff;
      sh_a_in       = sh_a_ff;
      sh_b_in       = sh_b_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;

      // register writes; unknown indexes drop
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_FIRST_MAX:  fmax_in = csr_chan.data[FIRST_MAX_W-1:0];
            CSR_SECOND_MAX: smax_in = csr_chan.data[SECOND_MAX_W-1:0];
            CSR_ICM_MAX:    icm_in  = csr_chan.data[ICM_W-1:0];
            default: ;
         endcase
      end

      // retire the held beat
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               src_in   = req_chan.source_clock;
               dst_in   = req_chan.target_clock;
               k_in     = K_W'(1);
               have_in  = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (k_ff > K_W'(FIRST_DIVIDER_LIMIT)) begin
               state_in = ST_FINISH;
            end else if (eligible) begin
               dvs_in   = {cand_d, 1'b0};
               numsh_in = num_load;
               numk_in  = num_load;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               k_in = K_W'(k_ff + 1'b1);
            end
         end
         ST_DIV: begin
            rem_in   = trial_ge ? (trial - N_W'(dvs_ff)) : trial;
            numsh_in = {numsh_ff[N_W-2:0], trial_ge};
            cnt_in   = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(N_W - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!q_ok) begin
               k_in     = K_W'(k_ff + 1'b1);
               state_in = ST_CHECK;
            end else if (!have_ff) begin
               // first fitting pair wins outright
               have_in     = 1'b1;
               best_n_in   = n_cand;
               best_den_in = den_cand;
               best1_in    = k_ff;
               best2_in    = numsh_ff[SECOND_DIVIDER_BITS-1:0];
               k_in        = K_W'(k_ff + 1'b1);
               state_in    = ST_CHECK;
            end else begin
               n_in     = n_cand;
               den_in   = den_cand;
               q_in     = numsh_ff[SECOND_DIVIDER_BITS-1:0];
               acc_a_in = '0;
               acc_b_in = '0;
               sh_a_in  = best_den_ff;
               sh_b_in  = den_cand;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // n * best_den against best_n * den, MSB first
            acc_a_in = (acc_a_ff << 1) + (sh_a_ff[DEN_W-1] ? PROD_W'(n_ff) : '0);
            acc_b_in = (acc_b_ff << 1) + (sh_b_ff[DEN_W-1] ? PROD_W'(best_n_ff) : '0);
            sh_a_in  = sh_a_ff << 1;
            sh_b_in  = sh_b_ff << 1;
            cnt_in   = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(DEN_W - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // strictly smaller error only, so the smallest k keeps ties
            if (acc_a_ff < acc_b_ff) begin
               best_n_in   = n_ff;
               best_den_in = den_ff;
               best1_in    = k_ff;
               best2_in    = q_ff;
            end
            k_in     = K_W'(k_ff + 1'b1);
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = have_ff;
               rsp_first_in  = have_ff ? FIRST_OUT_W'(best1_ff) : '0;
               rsp_second_in = have_ff ? SECOND_OUT_W'(best2_ff) : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         cnt_ff       <= '0;
         have_ff      <= 1'b0;
         fmax_ff      <= FIRST_MAX_RST;
         smax_ff      <= SECOND_MAX_RST;
         icm_ff       <= ICM_MAX_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         have_ff      <= have_in;
         fmax_ff      <= fmax_in;
         smax_ff      <= smax_in;
         icm_ff       <= icm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      dvs_ff        <= dvs_in;
      numsh_ff      <= numsh_in;
      numk_ff       <= numk_in;
      rem_ff        <= rem_in;
      n_ff          <= n_in;
      den_ff        <= den_in;
      q_ff          <= q_in;
      best_n_ff     <= best_n_in;
      best_den_ff   <= best_den_in;
      best1_ff      <= best1_in;
      best2_ff      <= best2_in;
      acc_a_ff      <= acc_a_in;
      acc_b_ff      <= acc_b_in;
      sh_a_ff       <= sh_a_in;
      sh_b_ff       <= sh_b_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

   // a not-found result carries zero dividers
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_first_ff == '0 && rsp_second_ff == '0))
      else $error("not-found result with nonzero dividers");

   // a found result never carries a zero divider
   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_first_ff != '0 && rsp_second_ff != '0))
      else $error("found result with a zero divider");

   // the candidate counter stops one past the limit
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (k_ff <= K_W'(FIRST_DIVIDER_LIMIT + 1)))
      else $error("first divider candidate out of range");

   // the divider never runs on a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (dvs_ff != '0))
      else $error("divide step with zero divisor");

   // reset leaves the block idle with nothing to deliver
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == ST_IDLE && !rsp_valid_ff))
      else $error("block not idle after reset");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for clock_divider_pair_search_core. A clocked driver
// feeds request beats from a queue. On every accepted beat a local divider
// search predicts the answer. A clocked monitor compares each response beat
// with the oldest prediction. Register settings change between phases, while
// the core is idle.
// ----------------------------------------------------------------------------
module tb;
   import cdps_pkg::*;

   localparam int CLOCK_HALF   = 2;
   localparam int RESET_CYCLES = 11;
   localparam int IDLE_PERCENT = 32;
   localparam int HOLD_AFTER   = 40;       // results seen before the long hold
   localparam int HOLD_CYCLES  = 6000;     // long enough for the core to back up
   localparam int DRAIN_CYCLES = 2200;     // worst request latency plus margin
   localparam int CYCLE_LIMIT  = 3000000;
   localparam int PHASE_ITEMS  = 45;

   // index outside the register map; the core must ignore it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct packed {
      logic [CLK_W-1:0] source;
      logic [CLK_W-1:0] target;
   } clock_request_type;

   typedef struct packed {
      logic                    found;
      logic [FIRST_OUT_W-1:0]  first;
      logic [SECOND_OUT_W-1:0] second;
   } divider_pick_type;

   logic clock;
   logic reset;

   cdps_req_if req_bus ();
   cdps_rsp_if rsp_bus ();
   cdps_csr_if csr_bus ();

   clock_divider_pair_search_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // local copy of the register file, updated on each accepted write beat
   logic [FIRST_MAX_W-1:0]  cfg_first_max  = FIRST_MAX_RST;
   logic [SECOND_MAX_W-1:0] cfg_second_max = SECOND_MAX_RST;
   logic [ICM_W-1:0]        cfg_icm        = ICM_MAX_RST;

   clock_request_type queued_requests[$];   // requests not yet offered
   divider_pick_type  pending_picks[$];     // predicted responses in flight

   int  mismatches  = 0;
   int  results_seen = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;
   bit  steady      = 1'b0;            // set for a phase with no idling at all
   int  cycle_count = 0;

   // -------------------------------------------------------------------------
   // Clock and watchdog
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[clock_divider_pair_search_core] ERROR");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Divider search predictor
   // Walk every first divider from the start value up to the clamped maximum,
   // round the second divider with halves going up, and keep a candidate only
   // when its error, held as the exact ratio |target*d1*d2 - source|/(d1*d2),
   // is strictly smaller. Comparing by cross multiplication keeps the lowest
   // first divider on a tie.
   // -------------------------------------------------------------------------
   function automatic divider_pick_type search_dividers(input logic [CLK_W-1:0] src,
                                                        input logic [CLK_W-1:0] dst);
      logic [63:0]  icm, start, d1max, d2cap, d2max;
      logic [63:0]  d, q, p, n, den, best_n, best_den, best1, best2;
      logic [127:0] lhs, rhs;
      logic         have;
      divider_pick_type pick;
      pick     = '0;
      have     = 1'b0;
      best_n   = 0;
      best_den = 1;
      best1    = 0;
      best2    = 0;
      if (dst == 0)
         return pick;
      // a zero limit behaves as one
      icm   = (cfg_icm == 0) ? 64'd1 : 64'(cfg_icm);
      start = 64'(src) / icm;
      if (start < 1)
         start = 1;
      d1max = (cfg_first_max > FIRST_DIVIDER_LIMIT) ? 64'(FIRST_DIVIDER_LIMIT)
                                                    : 64'(cfg_first_max);
      d2cap = (64'd1 << SECOND_DIVIDER_BITS) - 1;
      d2max = (64'(cfg_second_max) < d2cap) ? 64'(cfg_second_max) : d2cap;
      for (int k = 1; k <= FIRST_DIVIDER_LIMIT; k++) begin
         if (64'(k) < start || 64'(k) > d1max)
            continue;
         d = 64'(dst) * 64'(k);
         q = (64'd2 * 64'(src) + d) / (64'd2 * d);
         if (q < 1 || q > d2max)
            continue;
         p   = d * q;
         n   = (p > 64'(src)) ? p - 64'(src) : 64'(src) - p;
         den = 64'(k) * q;
         lhs = 128'(n) * 128'(best_den);
         rhs = 128'(best_n) * 128'(den);
         if (!have || lhs < rhs) begin
            have     = 1'b1;
            best_n   = n;
            best_den = den;
            best1    = 64'(k);
            best2    = q;
         end
      end
      if (have) begin
         pick.found  = 1'b1;
         pick.first  = best1[FIRST_OUT_W-1:0];
         pick.second = best2[SECOND_OUT_W-1:0];
      end
      return pick;
   endfunction

   // -------------------------------------------------------------------------
   // Request generator
   // Most requests are built backwards from a divider pair so that the search
   // finds something; the rest are raw 32-bit noise, which toggles every bit.
   // -------------------------------------------------------------------------
   function automatic clock_request_type make_request();
      clock_request_type req;
      int unsigned  k, q, kind;
      kind = $urandom_range(99);
      req.source = $urandom;
      req.target = $urandom;
      if (kind < 25) begin
         // raw noise; now and then a zero target
         if ($urandom_range(15) == 0)
            req.target = '0;
      end else begin
         k = $urandom_range(FIRST_DIVIDER_LIMIT, 1);
         q = ($urandom_range(3) == 0) ? $urandom_range(65535, 1) : $urandom_range(255, 1);
         // keep the source in reach of the intermediate limit most of the time
         if (kind < 70)
            req.source = $urandom_range(400000000, 1000);
         req.target = req.source / (k * q);
         if (req.target == 0)
            req.target = 1;
         // nudge off the exact ratio to exercise rounding and error compare
         if ($urandom_range(1) == 1)
            req.target = req.target + $urandom_range(req.target / 512 + 1);
      end
      return req;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: offer queued beats, idling at random unless steady
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      clock_request_type nxt;
      if (reset) begin
         req_bus.valid        <= 1'b0;
         req_bus.source_clock <= '0;
         req_bus.target_clock <= '0;
      end else begin
         // predict on the beat that lands at this edge
         if (req_bus.valid && req_bus.ready)
            pending_picks.push_back(search_dividers(req_bus.source_clock,
                                                    req_bus.target_clock));
         if (!req_bus.valid || req_bus.ready) begin
            if (queued_requests.size() != 0 &&
                (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
               nxt = queued_requests.pop_front();
               req_bus.valid        <= 1'b1;
               req_bus.source_clock <= nxt.source;
               req_bus.target_clock <= nxt.target;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: compare each beat with the oldest prediction, and
   // stall the response side at random plus one long hold
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      divider_pick_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pending_picks.size() == 0) begin
               $error("response beat with nothing expected: found %0d first %0d second %0d",
                      rsp_bus.found, rsp_bus.first_divider, rsp_bus.second_divider);
               mismatches++;
            end else begin
               want = pending_picks.pop_front();
               if (rsp_bus.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
                  mismatches++;
               end
               if (rsp_bus.first_divider !== want.first) begin
                  $error("first_divider: expected %0d, got %0d",
                         want.first, rsp_bus.first_divider);
                  mismatches++;
               end
               if (rsp_bus.second_divider !== want.second) begin
                  $error("second_divider: expected %0d, got %0d",
                         want.second, rsp_bus.second_divider);
                  mismatches++;
               end
            end
         end
         // hold off once for long enough that the core backs up onto requests
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Register write: one beat, then mirror it into the local register copy
   // -------------------------------------------------------------------------
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready));
      case (idx)
         CSR_FIRST_MAX:  cfg_first_max  = value[FIRST_MAX_W-1:0];
         CSR_SECOND_MAX: cfg_second_max = value[SECOND_MAX_W-1:0];
         CSR_ICM_MAX:    cfg_icm        = value[ICM_W-1:0];
         default: ;      // unmapped index: drop the write
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   // all three registers, with random junk above the first and second maximum fields
   task automatic write_settings(input logic [FIRST_MAX_W-1:0]  first_max,
                                 input logic [SECOND_MAX_W-1:0] second_max,
                                 input logic [ICM_W-1:0]        icm_max);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      write_register(CSR_FIRST_MAX,
                     {junk[CSR_DATA_W-1:FIRST_MAX_W], first_max});
      junk = $urandom;
      write_register(CSR_SECOND_MAX,
                     {junk[CSR_DATA_W-1:SECOND_MAX_W], second_max});
      write_register(CSR_ICM_MAX, icm_max);
   endtask

   // wait, sampling away from the active edge, until nothing is in flight
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_bus.valid || pending_picks.size() != 0);
   endtask

   task automatic queue_random(input int count);
      repeat (count) queued_requests.push_back(make_request());
   endtask

   task automatic queue_pair(input logic [CLK_W-1:0] src, input logic [CLK_W-1:0] dst);
      clock_request_type req;
      req.source = src;
      req.target = dst;
      queued_requests.push_back(req);
   endtask

   // -------------------------------------------------------------------------
   // Sequence of phases
   // -------------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_FIRST_MAX;
      csr_bus.data         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed beats under the reset settings
      queue_pair(32'd48000000, 32'd115200);       // everyday UART case
      queue_pair(32'd0, 32'd115200);              // zero source: nothing rounds to one
      queue_pair(32'd48000000, 32'd0);            // zero target
      queue_pair(32'd0, 32'd0);
      queue_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // start above the first maximum
      queue_pair(32'hFFFF_FFFF, 32'd1);
      queue_pair(32'd3200000000, 32'd1000000);    // start lands exactly on 32
      queue_pair(32'd100000000, 32'd1);           // second divider always too big
      queue_pair(32'd100000000, 32'd1600);
      queue_pair(32'd1, 32'd1);                   // exact pair of ones
      queue_pair(32'd1, 32'hFFFF_FFFF);
      queue_pair(32'd3, 32'd2);                   // equal error: lowest first wins
      queue_pair(32'd5, 32'd2);
      queue_pair(32'd1000000, 32'd2000000);       // exact half rounds up to one
      queue_pair(32'd1000000, 32'd2000001);
      queue_pair(32'd2097120, 32'd1);             // second divider at its ceiling
      queue_pair(32'd2097121, 32'd1);
      queue_pair(32'd200000000, 32'd1000000);
      queue_pair(32'd12000000, 32'd9600);
      queue_pair(32'hAAAA_AAAA, 32'h5555_5555);
      queue_pair(32'h5555_5555, 32'hAAAA_AAAA);
      wait_drained();

      // widest search: all maxima, first maximum clamped to 32
      write_settings(6'h3F, 16'hFFFF, 32'hFFFF_FFFF);
      queue_random(PHASE_ITEMS);
      wait_drained();

      // tightest non-zero settings
      write_settings(6'd1, 16'd1, 32'd1);
      queue_random(PHASE_ITEMS);
      wait_drained();

      // all zero: nothing can qualify
      write_settings(6'd0, 16'd0, 32'd0);
      queue_random(10);
      wait_drained();

      // unmapped index, then the reset values again, with no idling
      write_register(CSR_UNUSED_IDX, $urandom);
      write_settings(FIRST_MAX_RST, SECOND_MAX_RST, ICM_MAX_RST);
      steady = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_drained();
      steady = 1'b0;

      // random settings
      write_settings(6'($urandom_range(FIRST_DIVIDER_LIMIT, 1)),
                     16'($urandom_range(65535, 1)),
                     $urandom_range(32'hF000_0000, 32'd1000000));
      queue_random(PHASE_ITEMS);
      wait_drained();

      write_settings(6'd16, 16'd255, 32'd50000000);
      queue_random(PHASE_ITEMS);
      wait_drained();

      write_settings(6'd32, 16'hFFFF, 32'd100000000);
      queue_random(PHASE_ITEMS);
      wait_drained();

      // let any stray beat show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_picks.size() == 0) begin
         $display("[clock_divider_pair_search_core] OK");
      end else begin
         $display("[clock_divider_pair_search_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== clock_divider_pair_search_core.f =====
rtl/core/cdps_pkg.sv
rtl/core/cdps_if.sv
rtl/core/clock_divider_pair_search_core.sv
sim/tb.sv
